// File: rtl/two_region_bitmap_block_allocator_assert.svh
// assertion macros for the two-region bitmap block allocator
// expects signals clk and rst in the scope of each use
`ifndef TWO_REGION_BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH
`define TWO_REGION_BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH

`ifndef ASSERT_OFF
// property checked at every edge outside reset
`define TRBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// condition in one cycle implies a condition in the next
`define TRBA_ASSERT_NEXT(lbl, cond, nxt, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error(msg);
`else
`define TRBA_ASSERT(lbl, prop, msg)
`define TRBA_ASSERT_NEXT(lbl, cond, nxt, msg)
`endif

`endif

// File: rtl/trba_pkg.sv
// constants and types of the two-region bitmap block allocator
// no dependencies; used by the allocator top level
package trba_pkg;

  // map geometry
  localparam int MAP_BYTES         = 512;
  localparam int META_BYTES        = 16;
  localparam int ADDRESSABLE_BYTES = 512;
  localparam int LIMIT_BYTES       = (MAP_BYTES < ADDRESSABLE_BYTES) ? MAP_BYTES
                                                                     : ADDRESSABLE_BYTES;
  localparam int META_END          = (META_BYTES < LIMIT_BYTES) ? META_BYTES : LIMIT_BYTES;

  // memory word organization, first block of a word in its top bit
  localparam int WORD_BYTES = 8;
  localparam int WORD_W     = 8 * WORD_BYTES;
  localparam int MEM_WORDS  = (LIMIT_BYTES + WORD_BYTES - 1) / WORD_BYTES;
  localparam int ADDR_W     = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  // word ranges of the two regions, upper bound exclusive
  localparam int META_LO_WORD = 0;
  localparam int META_HI_WORD = (META_END + WORD_BYTES - 1) / WORD_BYTES;
  localparam int DATA_LO_WORD = META_END / WORD_BYTES;
  localparam int DATA_HI_WORD = MEM_WORDS;
  localparam bit DATA_EMPTY   = (META_END >= LIMIT_BYTES);

  // field widths
  localparam int BLOCK_W = 12;
  localparam int TDATA_W = 16;

  // reset pattern of the first byte: blocks 0 and 1 reserved
  localparam logic [7:0] RESERVED_FIRST_BYTE = 8'h3F;

  // request codes
  localparam logic KIND_ALLOC  = 1'b0;
  localparam logic KIND_FREE   = 1'b1;
  localparam logic REGION_META = 1'b0;
  localparam logic REGION_DATA = 1'b1;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [ADDR_W:0]    wcount_t;
  typedef logic [BLOCK_W-1:0] block_t;

endpackage

// File: rtl/two_region_bitmap_block_allocator.sv
// two-region first-fit bitmap block allocator, top level
// depends on trba_pkg and two_region_bitmap_block_allocator_assert.svh

// The free map (one bit per block, set = free) sits in one synchronous RAM of
// 64-bit words, read one word per cycle through a single port. A free request
// reads its word when it is accepted and writes it back with the result load.
// An allocate scans its region one word per cycle, lowest block first, up to
// 2 words for the metadata region and up to 62 for the data region; on a hit
// it writes the word back with the result load, else it loads a not-found
// result. One request is in work at a time; a new request is taken as soon
// as the previous one has left for the output register, even while that
// result still waits to be taken. A per-word valid flag, cleared by reset,
// makes an unwritten word read as its reset pattern, so there is no clearing
// pass after reset.
`include "two_region_bitmap_block_allocator_assert.svh"

module two_region_bitmap_block_allocator
  import trba_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,   // [11:0] block_number, rest zero
  input  logic [1:0]         s_tuser,   // [0] kind, [1] region
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // [11:0] granted_block, rest zero
  output logic [0:0]         m_tuser    // [0] found
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_HIT  = 3'd2;
  localparam logic [2:0] S_FREE = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam word_t TOP_WORD = {1'b1, {(WORD_W-1){1'b0}}};

  logic [2:0]           state, state_next;
  logic                 req_kind;
  logic                 req_region;
  logic [5:0]           req_off;
  word_t                mem [MEM_WORDS];
  logic [MEM_WORDS-1:0] valid;
  word_t                rdata;
  addr_t                raddr_q;
  logic                 rd_en;
  addr_t                rd_addr;
  logic                 wr_en;
  word_t                wr_data;
  word_t                eff_word;
  word_t                masked;
  wcount_t              hi_word;
  logic                 scan_last;
  logic                 out_free;
  logic                 load_out;
  logic                 out_found;
  block_t               out_block;
  logic [7:0]           byte_nz;
  logic [2:0]           hit_byte;
  logic [7:0]           sel_byte;
  logic [2:0]           hit_pos;
  logic [5:0]           hit_off;
  logic                 free_in_range;
  block_t               in_block;

  // reset pattern of a map word
  function automatic word_t reset_word(input addr_t a);
    word_t w;
    w = '1;
    if (a == '0) begin
      w[WORD_W-1 -: 8] = RESERVED_FIRST_BYTE;
    end
    return w;
  endfunction

  // bytes of a word that belong to the requested region
  function automatic word_t region_mask(input addr_t a, input logic rgn);
    word_t m;
    int    idx;
    int    lo;
    int    hi;
    m  = '0;
    lo = (rgn == REGION_DATA) ? META_END : 0;
    hi = (rgn == REGION_DATA) ? LIMIT_BYTES : META_END;
    for (int j = 0; j < WORD_BYTES; j++) begin
      idx = int'(a) * WORD_BYTES + j;
      if (idx >= lo && idx < hi) begin
        m[WORD_W-1-8*j -: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign in_block = s_tdata[BLOCK_W-1:0];
  assign free_in_range = (int'(in_block[BLOCK_W-1:3]) < LIMIT_BYTES);

  // word as stored, or its reset pattern if never written
  assign eff_word = valid[raddr_q] ? rdata : reset_word(raddr_q);
  assign masked   = eff_word & region_mask(raddr_q, req_region);
  assign hi_word  = (req_region == REGION_DATA) ? wcount_t'(DATA_HI_WORD)
                                                : wcount_t'(META_HI_WORD);
  assign scan_last = ({1'b0, raddr_q} + wcount_t'(1)) >= hi_word;

  // first free block in the hit word: byte, then bit
  always_comb begin
    for (int j = 0; j < WORD_BYTES; j++) begin
      byte_nz[j] = |masked[WORD_W-1-8*j -: 8];
    end
    hit_byte = '0;
    for (int j = WORD_BYTES - 1; j >= 0; j--) begin
      if (byte_nz[j]) begin
        hit_byte = 3'(j);
      end
    end
    sel_byte = 8'(masked >> (WORD_W - 8 - 8 * int'(hit_byte)));
    hit_pos = '0;
    for (int p = 7; p >= 0; p--) begin
      if (sel_byte[7-p]) begin
        hit_pos = 3'(p);
      end
    end
    hit_off = {hit_byte, hit_pos};
  end

  // sequencer
  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = addr_t'({1'b0, raddr_q} + wcount_t'(1));
    wr_en      = 1'b0;
    wr_data    = eff_word;
    load_out   = 1'b0;
    out_found  = 1'b0;
    out_block  = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser[0] == KIND_FREE) begin
            if (free_in_range) begin
              rd_en      = 1'b1;
              rd_addr    = in_block[6 +: ADDR_W];
              state_next = S_FREE;
            end else begin
              state_next = S_DONE;
            end
          end else if (s_tuser[1] == REGION_DATA && DATA_EMPTY) begin
            state_next = S_DONE;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = (s_tuser[1] == REGION_DATA) ? addr_t'(DATA_LO_WORD)
                                                     : addr_t'(META_LO_WORD);
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (masked != '0) begin
          state_next = S_HIT;
        end else if (scan_last) begin
          state_next = S_DONE;
        end else begin
          rd_en = 1'b1;
        end
      end
      S_HIT: begin
        if (out_free) begin
          wr_en      = 1'b1;
          wr_data    = eff_word & ~(TOP_WORD >> hit_off);
          load_out   = 1'b1;
          out_found  = 1'b1;
          out_block  = block_t'({raddr_q, hit_off});
          state_next = S_IDLE;
        end
      end
      S_FREE: begin
        if (out_free) begin
          wr_en      = 1'b1;
          wr_data    = eff_word | (TOP_WORD >> req_off);
          load_out   = 1'b1;
          out_found  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          load_out   = 1'b1;
          out_found  = (req_kind == KIND_FREE);
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        valid[raddr_q] <= 1'b1;
      end
    end
  end

  // request capture and read address
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_kind   <= s_tuser[0];
      req_region <= s_tuser[1];
      req_off    <= in_block[5:0];
    end
    if (rd_en) begin
      raddr_q <= rd_addr;
    end
  end

  // map memory, one read or one write per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[raddr_q] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tuser <= out_found;
      m_tdata <= TDATA_W'(out_block);
    end
  end

  `TRBA_ASSERT(a_scan_in_region, state != S_SCAN || wcount_t'(raddr_q) < hi_word, "scan left region")
  `TRBA_ASSERT(a_hit_has_free, state != S_HIT || masked != '0, "hit state without a free block")
  `TRBA_ASSERT(a_alloc_clears_one, !(state == S_HIT && wr_en) || $countones(eff_word ^ wr_data) == 1, "allocate must clear exactly one bit")
  `TRBA_ASSERT(a_not_found_zero, !(m_tvalid && !m_tuser[0]) || m_tdata == '0, "not found result with nonzero block")
  `TRBA_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, state != S_IDLE, "accepted request left no work")

endmodule

// File: verif/two_region_bitmap_block_allocator_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the two-region bitmap block allocator
// depends on trba_pkg and the allocator top level; stream ports on both sides

module two_region_bitmap_block_allocator_tb
  import trba_pkg::*;
();

  // one reply: found flag and granted block
  typedef struct packed {
    logic   found;
    block_t blk_num;
  } grant_t;

  // directed row: request fields and the reply read off by hand
  typedef struct packed {
    logic   kind;
    logic   region;
    block_t blk_num;
    logic   found;
    block_t granted;
  } dir_row_t;

  localparam int DIR_ROWS = 18;
  localparam int RAND_PER_PHASE = 345;
  localparam int DRAIN_CYCLES = 200;

  // after reset blocks 0 and 1 are reserved, so the first metadata grant is 2
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    {KIND_ALLOC, REGION_META, 12'd0,    1'b1, 12'd2},
    {KIND_ALLOC, REGION_DATA, 12'd0,    1'b1, 12'd128},
    {KIND_ALLOC, REGION_META, 12'd4095, 1'b1, 12'd3},    // block field ignored
    {KIND_FREE,  REGION_META, 12'd2,    1'b1, 12'd0},
    {KIND_ALLOC, REGION_META, 12'd0,    1'b1, 12'd2},    // freed block comes back first
    {KIND_FREE,  REGION_META, 12'd0,    1'b1, 12'd0},    // reserved block is not protected
    {KIND_ALLOC, REGION_META, 12'd0,    1'b1, 12'd0},
    {KIND_FREE,  REGION_DATA, 12'd4095, 1'b1, 12'd0},    // region ignored, top block
    {KIND_FREE,  REGION_META, 12'd4095, 1'b1, 12'd0},    // freeing a free block
    {KIND_ALLOC, REGION_DATA, 12'd0,    1'b1, 12'd129},
    {KIND_FREE,  REGION_META, 12'd128,  1'b1, 12'd0},
    {KIND_ALLOC, REGION_DATA, 12'd0,    1'b1, 12'd128},
    {KIND_FREE,  REGION_META, 12'd1,    1'b1, 12'd0},
    {KIND_ALLOC, REGION_META, 12'd0,    1'b1, 12'd1},
    {KIND_ALLOC, REGION_META, 12'd0,    1'b1, 12'd4},
    {KIND_FREE,  REGION_META, 12'd3,    1'b1, 12'd0},
    {KIND_FREE,  REGION_META, 12'd3,    1'b1, 12'd0},    // double free
    {KIND_ALLOC, REGION_META, 12'd0,    1'b1, 12'd3}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata = '0;   // [11:0] block_number, rest zero
  logic [1:0]         s_tuser = '0;   // [0] kind, [1] region
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;        // [11:0] granted_block, rest zero
  logic [0:0]         m_tuser;        // [0] found

  // shadow free map, set bit = free, top bit of a byte is the lowest block
  logic [7:0] shadow_map [MAP_BYTES];
  grant_t     pending_grants[$];
  block_t     held_blocks[$];
  int         src_idle_pct = 24;
  int         snk_idle_pct = 83;
  int         errors = 0;

  two_region_bitmap_block_allocator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  // first-fit allocation and free on the shadow map
  function automatic grant_t allocate_or_free(logic kind, logic region, block_t blk);
    grant_t g;
    int     lim;
    int     meta_end;
    int     lo;
    int     hi;
    g = '0;
    if (kind == KIND_FREE) begin
      if (int'(blk >> 3) < MAP_BYTES) shadow_map[blk >> 3][7 - blk[2:0]] = 1'b1;
      g.found = 1'b1;
      return g;
    end
    lim      = (MAP_BYTES < ADDRESSABLE_BYTES) ? MAP_BYTES : ADDRESSABLE_BYTES;
    meta_end = (META_BYTES < lim) ? META_BYTES : lim;
    lo       = (region == REGION_META) ? 0 : meta_end;
    hi       = (region == REGION_META) ? meta_end : lim;
    for (int i = lo; i < hi && !g.found; i++) begin
      for (int p = 0; p < 8 && !g.found; p++) begin
        if (shadow_map[i][7 - p]) begin
          shadow_map[i][7 - p] = 1'b0;
          g.found   = 1'b1;
          g.blk_num = block_t'(i * 8 + p);
        end
      end
    end
    return g;
  endfunction

  // one request transfer; the reply is predicted once it is accepted
  task automatic send_request(input logic kind, input logic region, input block_t blk,
                              input bit typed, input grant_t typed_grant);
    grant_t g;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= TDATA_W'(blk);
    s_tuser  <= {region, kind};
    do @(posedge clk); while (!s_tready);
    g = allocate_or_free(kind, region, blk);
    if (kind == KIND_ALLOC && g.found) held_blocks.push_back(g.blk_num);
    pending_grants.push_back(typed ? typed_grant : g);
  endtask

  // hold off the sender until every reply is back
  task automatic wait_replies();
    s_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
  endtask

  // mostly allocations and frees of held blocks, some stray and reserved frees
  task automatic run_random(input int count);
    int     sel;
    int     idx;
    logic   kind;
    logic   region;
    block_t blk;
    for (int n = 0; n < count; n++) begin
      sel    = $urandom_range(0, 99);
      region = 1'($urandom_range(0, 1));
      blk    = block_t'($urandom_range(0, 4095));
      if (sel < 38) begin
        kind   = KIND_ALLOC;
        region = REGION_META;
      end else if (sel < 62) begin
        kind   = KIND_ALLOC;
        region = REGION_DATA;
      end else if (sel < 84 && held_blocks.size() != 0) begin
        kind = KIND_FREE;
        idx  = $urandom_range(0, held_blocks.size() - 1);
        blk  = held_blocks[idx];
        held_blocks.delete(idx);
      end else if (sel < 94) begin
        kind = KIND_FREE;
      end else begin
        kind = KIND_FREE;
        blk  = block_t'($urandom_range(0, 1));
      end
      send_request(kind, region, blk, 1'b0, '0);
    end
  endtask

  // receiver: random back-pressure and reply check
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
      if (m_tvalid && m_tready) begin
        if (pending_grants.size() == 0) begin
          $display("%0t: reply with none expected, found %0d block %0d",
                   $time, m_tuser[0], m_tdata[BLOCK_W-1:0]);
          errors++;
        end else begin
          if (m_tuser[0] !== pending_grants[0].found) begin
            $display("%0t: found mismatch, expected %0d actual %0d",
                     $time, pending_grants[0].found, m_tuser[0]);
            errors++;
          end
          if (m_tdata !== TDATA_W'(pending_grants[0].blk_num)) begin
            $display("%0t: granted_block mismatch, expected %0d actual %0d",
                     $time, pending_grants[0].blk_num, m_tdata);
            errors++;
          end
          void'(pending_grants.pop_front());
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    for (int i = 0; i < MAP_BYTES; i++) shadow_map[i] = 8'hFF;
    shadow_map[0] = RESERVED_FIRST_BYTE;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      send_request(DIRECTED[r].kind, DIRECTED[r].region, DIRECTED[r].blk_num, 1'b1,
                   {DIRECTED[r].found, DIRECTED[r].granted});
    end
    wait_replies();

    run_random(RAND_PER_PHASE);
    wait_replies();
    src_idle_pct = 83;
    snk_idle_pct = 24;
    run_random(RAND_PER_PHASE);
    wait_replies();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_random(RAND_PER_PHASE);
    wait_replies();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && pending_grants.size() == 0) begin
      $display("PASS two_region_bitmap_block_allocator");
    end else begin
      $display("FAIL two_region_bitmap_block_allocator");
    end
    $finish;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("FAIL two_region_bitmap_block_allocator");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/trba_pkg.sv
rtl/two_region_bitmap_block_allocator.sv
verif/two_region_bitmap_block_allocator_tb.sv
